// ===== design/tilt_angle_deflection_filter_top_defines.svh =====
// Assertion macros for the tilt filter checker
`ifndef TILT_ANGLE_DEFLECTION_FILTER_TOP_DEFINES_SVH
`define TILT_ANGLE_DEFLECTION_FILTER_TOP_DEFINES_SVH
`define TADF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define TADF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ===== design/tadf_pkg.sv =====
package tadf_pkg;
  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);
  localparam logic [31:0] InvGainQ30 = 32'd652032874;
  localparam logic [14:0] ChipOffset = 15'd230;
  localparam logic [13:0] LeverReset = 14'd500;
  localparam logic [15:0] AlphaReset = 16'd9830;
  localparam logic [1:0] RegLever = 2'd0;
  localparam logic [1:0] RegAlpha = 2'd1;

  typedef enum logic [2:0] {
    OP_NONE, OP_TILT_INIT, OP_TILT_STEP, OP_FILTER, OP_SINE_INIT,
    OP_SINE_STEP, OP_OUTPUT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [StepW-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic calibrate;
  } status_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction
endpackage

// ===== design/tadf_datapath.sv =====
module tadf_datapath (
  input  logic                clk_i,
  input  logic                load_i,
  input  logic                action_i,
  input  logic signed [15:0]  accel_x_i,
  input  logic signed [15:0]  accel_z_i,
  input  tadf_pkg::cmd_t      cmd_i,
  input  logic [13:0]         lever_i,
  input  logic [15:0]         alpha_i,
  input  logic                rst_ni,
  output tadf_pkg::status_t   status_o,
  output logic signed [15:0]  angle_o,
  output logic signed [14:0]  defl_o
);
  logic signed [19:0] x_q, x_d, y_q, y_d;
  logic [31:0] acc_q, acc_d;
  logic signed [33:0] sx_q, sx_d, sy_q, sy_d, sa_q, sa_d;
  logic signed [31:0] f_q, f_d;
  logic [15:0] zero_q, zero_d;
  logic act_q;
  logic signed [16:0] ax_q, az_q;
  logic [4:0] idx;
  logic [31:0] at;
  logic [15:0] tilt, tilt_v, diff;
  logic vec_zero;
  logic signed [49:0] fsum;
  logic signed [32:0] fneg, fmag;
  logic [48:0] aprod;
  logic signed [33:0] sq;
  logic signed [15:0] sine;
  logic [15:0] smag;
  logic [14:0] lev;
  logic [30:0] dprod;
  logic [15:0] dmag;
  logic signed [15:0] ang_d;
  logic signed [14:0] defl_d;
  logic signed [15:0] ang_q;
  logic signed [14:0] defl_q;

  assign idx = 5'(cmd_i.step);
  assign at = tadf_pkg::atan_turn(idx);
  assign tilt = 16'((acc_q + 32'h8000) >> 16);
  assign vec_zero = (ax_q == 17'sd0) && (az_q == 17'sd0);
  assign tilt_v = vec_zero ? 16'h0 : tilt;
  assign diff = tilt_v - zero_q;
  assign fsum = 50'(signed'({1'b0, alpha_i})) * 50'(signed'(diff)) * 50'sd65536
              + 50'(signed'({1'b0, 17'h10000 - {1'b0, alpha_i}})) * 50'(f_q);
  assign fneg = -33'(f_q);
  assign fmag = f_q < 0 ? fneg : 33'(f_q);
  assign aprod = 49'(fmag) * 49'd36000;
  assign sq = (sy_q + 34'sd16384) >>> 15;
  assign sine = sq > 34'sd32767 ? 16'sd32767 : (sq < -34'sd32768 ? -16'sd32768 : 16'(sq));
  assign smag = sine < 0 ? 16'(-17'(sine)) : 16'(sine);
  assign lev = 15'(lever_i) + tadf_pkg::ChipOffset;
  assign dprod = 31'(smag) * 31'(lev);
  assign dmag = 16'(dprod >> 15);
  assign status_o.calibrate = act_q;
  assign angle_o = ang_q;
  assign defl_o = defl_q;

  always_comb begin
    x_d = x_q; y_d = y_q; acc_d = acc_q; sx_d = sx_q; sy_d = sy_q; sa_d = sa_q;
    f_d = f_q; zero_d = zero_q; ang_d = ang_q; defl_d = defl_q;
    case (cmd_i.op)
      tadf_pkg::OP_TILT_INIT: begin
        acc_d = 32'h0;
        if (az_q > 0) begin
          x_d = 20'(az_q); y_d = 20'(ax_q); acc_d = 32'h80000000;
        end else begin
          x_d = 20'(-az_q); y_d = 20'(-ax_q);
        end
      end
      tadf_pkg::OP_TILT_STEP: begin
        if (y_q >= 0) begin
          x_d = x_q + (y_q >>> idx); y_d = y_q - (x_q >>> idx); acc_d = acc_q + at;
        end else begin
          x_d = x_q - (y_q >>> idx); y_d = y_q + (x_q >>> idx); acc_d = acc_q - at;
        end
      end
      tadf_pkg::OP_FILTER: begin
        if (act_q) begin
          zero_d = tilt_v;
          f_d = 32'sd0;
        end else begin
          f_d = 32'(fsum >>> 16);
        end
      end
      tadf_pkg::OP_SINE_INIT: begin
        sx_d = 34'(tadf_pkg::InvGainQ30); sy_d = 34'sd0;
        if (f_q > 32'sh40000000) sa_d = 34'sh80000000 - 34'(f_q);
        else if (f_q < -32'sh40000000) sa_d = -34'sh80000000 - 34'(f_q);
        else sa_d = 34'(f_q);
      end
      tadf_pkg::OP_SINE_STEP: begin
        if (sa_q >= 0) begin
          sx_d = sx_q - (sy_q >>> idx); sy_d = sy_q + (sx_q >>> idx);
          sa_d = sa_q - 34'(at);
        end else begin
          sx_d = sx_q + (sy_q >>> idx); sy_d = sy_q - (sx_q >>> idx);
          sa_d = sa_q + 34'(at);
        end
      end
      tadf_pkg::OP_OUTPUT: begin
        ang_d = f_q < 0 ? 16'(-17'(aprod >> 32)) : 16'(aprod >> 32);
        if (dmag > 16'd16383) defl_d = sine < 0 ? -15'sd16383 : 15'sd16383;
        else defl_d = sine < 0 ? 15'(-16'(dmag)) : 15'(dmag);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= 32'sd0;
      zero_q <= 16'h0;
      ang_q <= 16'sd0;
      defl_q <= 15'sd0;
    end else begin
      f_q <= f_d;
      zero_q <= zero_d;
      ang_q <= ang_d;
      defl_q <= defl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      act_q <= action_i;
      ax_q <= 17'(accel_x_i);
      az_q <= 17'(accel_z_i);
    end
    x_q <= x_d; y_q <= y_d; acc_q <= acc_d;
    sx_q <= sx_d; sy_q <= sy_d; sa_q <= sa_d;
  end
endmodule

// ===== design/tadf_ctrl.sv =====
module tadf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              load_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  tadf_pkg::status_t status_i,
  output tadf_pkg::cmd_t    cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_TINIT, S_TSTEP, S_FILT, S_SINIT, S_SSTEP, S_OUT
  } state_e;
  state_e state_q;
  logic [tadf_pkg::StepW-1:0] step_q;
  logic out_valid_q;
  logic out_free;
  localparam logic [tadf_pkg::StepW-1:0] Last = tadf_pkg::StepW'(tadf_pkg::CordicSteps - 1);

  assign in_ready_o = (state_q == S_IDLE);
  assign load_o = in_ready_o && in_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.step = step_q;
    unique case (state_q)
      S_TINIT: cmd_o.op = tadf_pkg::OP_TILT_INIT;
      S_TSTEP: cmd_o.op = tadf_pkg::OP_TILT_STEP;
      S_FILT:  cmd_o.op = tadf_pkg::OP_FILTER;
      S_SINIT: cmd_o.op = tadf_pkg::OP_SINE_INIT;
      S_SSTEP: cmd_o.op = tadf_pkg::OP_SINE_STEP;
      S_OUT:   cmd_o.op = out_free ? tadf_pkg::OP_OUTPUT : tadf_pkg::OP_NONE;
      default: cmd_o.op = tadf_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (load_o) state_q <= S_TINIT;
        S_TINIT: begin
          step_q <= '0;
          state_q <= S_TSTEP;
        end
        S_TSTEP: begin
          step_q <= step_q + 1'b1;
          if (step_q == Last) state_q <= S_FILT;
        end
        S_FILT: state_q <= status_i.calibrate ? S_IDLE : S_SINIT;
        S_SINIT: begin
          step_q <= '0;
          state_q <= S_SSTEP;
        end
        S_SSTEP: begin
          step_q <= step_q + 1'b1;
          if (step_q == Last) state_q <= S_OUT;
        end
        S_OUT: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/tilt_angle_deflection_filter_top.sv =====
// Channel  | dir | tdata (low to high)                 | tuser
// s_axis   | in  | accel_x[15:0], accel_z[31:16]       | action
// m_axis   | out | angle_centideg[15:0], defl[30:16]   | -
// An item runs accept, init, 16 tilt CORDIC steps, filter, sine init, 16 sine
// CORDIC steps and output before the next accept; tvalid is registered from the
// output step. A calibrate item returns to accept after the filter and gives no beat.
// Reset is asynchronous, active low; it restores lever and alpha and clears the control, filter, zero and output state.
// A waiting result stalls only the next output step; new items are taken while it waits, but not during that stall.
module tilt_angle_deflection_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // accel_x, accel_z
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // angle_centideg, deflection_tenth_mm, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [13:0] lever_q;
  logic [15:0] alpha_q;
  logic load;
  tadf_pkg::cmd_t cmd;
  tadf_pkg::status_t status;
  logic signed [15:0] angle;
  logic signed [14:0] defl;

  assign pready = 1'b1;
  assign prdata = paddr[2] == tadf_pkg::RegAlpha[0] ? {16'h0, alpha_q} : {18'h0, lever_q};
  assign m_axis_tdata = {1'b0, defl, angle};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lever_q <= tadf_pkg::LeverReset;
      alpha_q <= tadf_pkg::AlphaReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == tadf_pkg::RegLever[0]) lever_q <= pwdata[13:0];
      else alpha_q <= pwdata[15:0];
    end
  end

  tadf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .load_o(load),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .status_i(status), .cmd_o(cmd)
  );

  tadf_datapath u_dp (
    .clk_i, .load_i(load), .action_i(s_axis_tuser),
    .accel_x_i(s_axis_tdata[15:0]), .accel_z_i(s_axis_tdata[31:16]),
    .cmd_i(cmd), .lever_i(lever_q), .alpha_i(alpha_q), .rst_ni,
    .status_o(status), .angle_o(angle), .defl_o(defl)
  );
endmodule

// ===== design/tadf_checker.sv =====
`include "tilt_angle_deflection_filter_top_defines.svh"
module tadf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  logic in_acc;
  logic out_wait;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_wait = m_axis_tvalid && !m_axis_tready;

  `TADF_ASSERT_NXT(accept_keeps_out, clk_i, rst_ni, in_acc, !$rose(m_axis_tvalid) && $stable(m_axis_tdata))
  `TADF_ASSERT_NXT(busy_after_accept, clk_i, rst_ni, in_acc, !s_axis_tready)
  `TADF_ASSERT_NXT(out_hold, clk_i, rst_ni, out_wait, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind tilt_angle_deflection_filter_top tadf_checker u_tadf_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [14:0] defl;
  } tilt_result_t;

  localparam logic [31:0] AtanTurn [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
  localparam int HoldLen = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tilt_angle_deflection_filter_top dut (.*);

  logic [13:0]  lever_reg;
  logic [15:0]  alpha_reg;
  logic [15:0]  zero_angle;
  logic [31:0]  filt_angle;
  tilt_result_t expected_q[$];
  int           errors = 0;
  int           beats_sent = 0;
  int           calibrations = 0;
  int           results_seen = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_cycles = 0;
  logic         hold_start = 1'b0;
  logic         hold_started = 1'b0;

  initial forever #4 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [15:0] tilt_bam(longint y, longint x);
    logic [31:0] acc;
    logic [31:0] rounded;
    longint dx, dy;
    acc = '0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h80000000;
    end
    for (int i = 0; i < tadf_pkg::CordicSteps; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y >= 0) begin
        x += dy;
        y -= dx;
        acc += AtanTurn[i];
      end else begin
        x -= dy;
        y += dx;
        acc -= AtanTurn[i];
      end
    end
    rounded = acc + 32'h8000;
    return rounded[31:16];
  endfunction

  function automatic longint sine_q15(longint a);
    longint x, y, dx, dy, s;
    x = longint'(tadf_pkg::InvGainQ30);
    y = 0;
    if (a > 64'sh40000000) a = 64'sh80000000 - a;
    else if (a < -64'sh40000000) a = -64'sh80000000 - a;
    for (int i = 0; i < tadf_pkg::CordicSteps; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (a >= 0) begin
        x -= dy;
        y += dx;
        a -= longint'(AtanTurn[i]);
      end else begin
        x += dy;
        y -= dx;
        a += longint'(AtanTurn[i]);
      end
    end
    s = (y + 16384) >>> 15;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s;
  endfunction

  function automatic void predict_tilt(logic action, logic [15:0] ax, logic [15:0] az);
    logic [15:0] tilt;
    logic [15:0] diff;
    longint d, f, mag, ang, s, defl;
    tilt_result_t r;
    tilt = tilt_bam(-longint'($signed(ax)), -longint'($signed(az)));
    if (action) begin
      zero_angle = tilt;
      filt_angle = '0;
      calibrations++;
      return;
    end
    diff = tilt - zero_angle;
    d = longint'($signed(diff));
    f = (longint'(alpha_reg) * d * 65536 +
         (65536 - longint'(alpha_reg)) * longint'($signed(filt_angle))) >>> 16;
    filt_angle = f[31:0];
    f = longint'($signed(filt_angle));
    mag = f < 0 ? -f : f;
    ang = (mag * 36000) >>> 32;
    if (f < 0) ang = -ang;
    s = sine_q15(f);
    mag = ((s < 0 ? -s : s) * (longint'(lever_reg) + longint'(tadf_pkg::ChipOffset))) >>> 15;
    defl = s < 0 ? -mag : mag;
    if (defl > 16383) defl = 16383;
    if (defl < -16383) defl = -16383;
    r.angle = ang[15:0];
    r.defl = defl[14:0];
    expected_q.push_back(r);
  endfunction

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_start && !hold_started) begin
      hold_started <= 1'b1;
      m_axis_tready <= 1'b0;
      hold_cycles <= HoldLen;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    tilt_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.angle = m_axis_tdata[15:0];
      got.defl = m_axis_tdata[30:16];
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat angle=%0d defl=%0d", $time, got.angle, got.defl);
      end else begin
        want = expected_q.pop_front();
        if (got.angle !== want.angle) begin
          errors++;
          $display("%0t: angle expected %0d actual %0d", $time, want.angle, got.angle);
        end
        if (got.defl !== want.defl) begin
          errors++;
          $display("%0t: deflection expected %0d actual %0d", $time, want.defl, got.defl);
        end
      end
    end
  end

  task automatic send_sample(logic action, logic [15:0] ax, logic [15:0] az);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = action;
    s_axis_tdata = {az, ax};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_tilt(action, ax, az);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = 3'(4 * int'(idx));
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == tadf_pkg::RegLever) lever_reg = value[13:0];
    else alpha_reg = value[15:0];
  endtask

  task automatic send_random(int count);
    logic [15:0] ax, az;
    for (int i = 0; i < count; i++) begin
      ax = 16'($urandom);
      az = 16'($urandom);
      case ($urandom_range(3))
        0: ax = 16'($urandom_range(255)) - 16'd128;
        1: az = 16'($urandom_range(255)) - 16'd128;
        default: ;
      endcase
      send_sample($urandom_range(99) < 6, ax, az);
    end
  endtask

  task automatic test_directed;
    send_sample(1'b0, 16'h0000, 16'h0000);
    send_sample(1'b0, 16'h8000, 16'h8000);
    send_sample(1'b0, 16'h7FFF, 16'h7FFF);
    send_sample(1'b0, 16'h8000, 16'h7FFF);
    send_sample(1'b0, 16'h7FFF, 16'h8000);
    send_sample(1'b0, 16'h8000, 16'h0000);
    send_sample(1'b0, 16'h0000, 16'h8000);
    send_sample(1'b0, 16'hFFFF, 16'h0001);
    send_sample(1'b1, 16'h0000, 16'h8000);
    send_sample(1'b0, 16'h0000, 16'h7FFF);
    send_sample(1'b0, 16'h0000, 16'h7FFF);
    send_sample(1'b1, 16'h0000, 16'h0000);
    send_sample(1'b0, 16'h1234, 16'hC000);
    send_sample(1'b1, 16'h4000, 16'h4000);
    send_sample(1'b0, 16'hC000, 16'hC000);
    drain();
  endtask

  task automatic test_config_sweep;
    logic [31:0] levers [4] = '{0, 10000, 500, 0};
    logic [31:0] alphas [4] = '{65535, 1, 9830, 0};
    levers[3] = $urandom_range(10000);
    alphas[3] = $urandom_range(65535, 1);
    for (int k = 0; k < 4; k++) begin
      write_reg(tadf_pkg::RegLever, levers[k]);
      write_reg(tadf_pkg::RegAlpha, alphas[k]);
      send_random(60);
      drain();
    end
  endtask

  task automatic test_flow_phases;
    int pcts [4][2] = '{'{0, 0}, '{87, 0}, '{0, 87}, '{10, 10}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pcts[p][0];
      recv_stall_pct = pcts[p][1];
      write_reg(tadf_pkg::RegLever, $urandom_range(10000));
      write_reg(tadf_pkg::RegAlpha, $urandom_range(65535, 1));
      send_random(350);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure;
    hold_start = 1'b1;
    send_random(40);
    drain();
  endtask

  initial begin
    lever_reg = tadf_pkg::LeverReset;
    alpha_reg = tadf_pkg::AlphaReset;
    zero_angle = '0;
    filt_angle = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_sweep();
    test_flow_phases();
    test_backpressure();
    $display("Sent %0d beats (%0d calibrations), checked %0d results,", beats_sent,
             calibrations, results_seen);
    $display("across lever/alpha extremes, idle and stall phases and a long hold-off.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/tadf_pkg.sv
design/tadf_datapath.sv
design/tadf_ctrl.sv
design/tilt_angle_deflection_filter_top.sv
design/tadf_checker.sv
dv/testbench.sv
